@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the heap queue sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define BMHQ_ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a condition implies another in the same cycle.
`define BMHQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/bmhq_pkg.sv @@
// Package: sizes, codes, types and the key compare of the heap queue.
package bmhq_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = IDX_W + 2;
   localparam int KEY_W    = 32;
   localparam int TAG_W    = 16;
   localparam int ENT_W    = KEY_W + TAG_W;
   localparam int COUNT_W  = 8;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic               done;
      entry_type          ent;
      logic               removed_valid;
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
   } result_type;

   // Signed compare of two keys: a > b.
   function automatic logic key_gt(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

endpackage

@@ hw/rtl/binary_max_heap_queue_top.sv @@
// Top level of the binary max-heap priority queue.
//
// Usage: a request item on req_* inserts (req_action 0) a signed Q16.16 key
// with a 16-bit tag, or removes (req_action 1) the entry of highest key.
// Every request yields exactly one response item on rsp_*: the removed key
// and tag with rsp_removed_valid, a status (ok, insert dropped when full,
// remove on empty) and the entry count after the request.
// A dropped insert or an empty remove is answered without touching the RAM.
// An insert climbs one level per step until it reaches the root or a compare
// stops it. A remove reads the root; unless that empties the queue, it moves
// the last entry to the root and sinks it one level per step, examining the
// children of each, until it rests at a leaf or a compare stops it.
// The single read port of the entry RAM and the one key comparator set this
// pace; one request is in work at a time, and the next request is accepted in
// the cycle after the response is taken.
// req_stall is high while a request is in work or a response waits.
// A stalled response holds its value until taken.
// Reset empties the queue at once; entry RAM contents need no clearing.
module binary_max_heap_queue_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic signed [bmhq_pkg::KEY_W-1:0] req_in_key,
   input  logic [bmhq_pkg::TAG_W-1:0]    req_in_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [bmhq_pkg::KEY_W-1:0] rsp_out_key,
   output logic [bmhq_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic                          rsp_removed_valid,
   output logic [1:0]                    rsp_status,
   output logic [bmhq_pkg::COUNT_W-1:0]  rsp_entry_count
);

   logic                         seq_idle;
   logic                         req_accept;
   bmhq_pkg::result_type         result;
   logic                         mem_wr_en, mem_rd_en;
   logic [bmhq_pkg::IDX_W-1:0]   mem_wr_addr, mem_rd_addr;
   logic [bmhq_pkg::ENT_W-1:0]   mem_wr_data, mem_rd_data;

   logic                         rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::result_type         rsp_ff;

   assign req_stall  = !seq_idle || rsp_valid_ff;
   assign req_accept = req_valid && !req_stall;

   bmhq_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .action      (req_action),
      .in_key      (req_in_key),
      .in_tag      (req_in_tag),
      .idle        (seq_idle),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bmhq_ram #(
      .WIDTH (bmhq_pkg::ENT_W),
      .DEPTH (bmhq_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Hold the response until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (result.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (result.done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_key       = rsp_ff.ent.key;
   assign rsp_out_tag       = rsp_ff.ent.tag;
   assign rsp_removed_valid = rsp_ff.removed_valid;
   assign rsp_status        = rsp_ff.status;
   assign rsp_entry_count   = rsp_ff.entry_count;

endmodule

@@ hw/rtl/bmhq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bmhq_seq.sv @@
// Sequencer of the heap queue: sift-up and sift-down over the entry RAM.
`include "assert_macros.svh"

module bmhq_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          action,
   input  logic [bmhq_pkg::KEY_W-1:0]    in_key,
   input  logic [bmhq_pkg::TAG_W-1:0]    in_tag,
   output logic                          idle,
   output bmhq_pkg::result_type          result,
   output logic                          mem_wr_en,
   output logic [bmhq_pkg::IDX_W-1:0]    mem_wr_addr,
   output logic [bmhq_pkg::ENT_W-1:0]    mem_wr_data,
   output logic                          mem_rd_en,
   output logic [bmhq_pkg::IDX_W-1:0]    mem_rd_addr,
   input  logic [bmhq_pkg::ENT_W-1:0]    mem_rd_data
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_UP_RD   = 10'b00_0000_0010,
      S_UP_CMP  = 10'b00_0000_0100,
      S_RM_ROOT = 10'b00_0000_1000,
      S_RM_LAST = 10'b00_0001_0000,
      S_DN_LOAD = 10'b00_0010_0000,
      S_DN_RDL  = 10'b00_0100_0000,
      S_DN_RDR  = 10'b00_1000_0000,
      S_DN_SEL  = 10'b01_0000_0000,
      S_DN_SWAP = 10'b10_0000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [bmhq_pkg::CNT_W-1:0]    fill_ff, fill_in;
   logic [bmhq_pkg::IDX_W-1:0]    cur_ff, cur_in;
   logic [bmhq_pkg::IDX_W-1:0]    big_idx_ff, big_idx_in;
   bmhq_pkg::entry_type           mov_ff, mov_in;
   bmhq_pkg::entry_type           big_ff, big_in;
   bmhq_pkg::entry_type           rm_ent_ff, rm_ent_in;
   logic                          rem_ff, rem_in;

   bmhq_pkg::entry_type           rd_ent;
   logic [bmhq_pkg::IDX_W-1:0]    parent_idx;
   logic [bmhq_pkg::CHILD_W-1:0]  left_w, right_w, fill_w;
   logic                          has_left, has_right;
   logic [bmhq_pkg::KEY_W-1:0]    cmp_a, cmp_b;
   logic                          gt;
   logic                          finish;
   bmhq_pkg::status_type          fin_status;
   logic                          removed;

   assign rd_ent     = bmhq_pkg::entry_type'(mem_rd_data);
   assign parent_idx = (cur_ff - bmhq_pkg::IDX_W'(1)) >> 1;
   assign left_w     = {1'b0, cur_ff, 1'b1};
   assign right_w    = left_w + bmhq_pkg::CHILD_W'(1);
   assign fill_w     = bmhq_pkg::CHILD_W'(fill_ff);
   assign has_left   = left_w < fill_w;
   assign has_right  = right_w < fill_w;

   // One comparator serves every step of both sifts.
   always_comb begin
      unique case (state_ff)
         S_UP_CMP: begin
            cmp_a = mov_ff.key;
            cmp_b = rd_ent.key;
         end
         S_DN_SEL: begin
            cmp_a = rd_ent.key;
            cmp_b = big_ff.key;
         end
         default: begin
            cmp_a = big_ff.key;
            cmp_b = mov_ff.key;
         end
      endcase
   end

   assign gt = bmhq_pkg::key_gt(cmp_a, cmp_b);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      cur_in      = cur_ff;
      big_idx_in  = big_idx_ff;
      mov_in      = mov_ff;
      big_in      = big_ff;
      rm_ent_in   = rm_ent_ff;
      rem_in      = rem_ff;
      finish      = 1'b0;
      fin_status  = bmhq_pkg::ST_OK;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_ff;
      mem_wr_data = mov_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rem_in = (action == bmhq_pkg::ACT_REMOVE);
               if (action == bmhq_pkg::ACT_INSERT) begin
                  if (fill_ff == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
                     finish     = 1'b1;
                     fin_status = bmhq_pkg::ST_FULL;
                  end else begin
                     mov_in   = '{key: in_key, tag: in_tag};
                     cur_in   = fill_ff[bmhq_pkg::IDX_W-1:0];
                     fill_in  = fill_ff + bmhq_pkg::CNT_W'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     finish     = 1'b1;
                     fin_status = bmhq_pkg::ST_EMPTY;
                  end else begin
                     fill_in  = fill_ff - bmhq_pkg::CNT_W'(1);
                     state_in = S_RM_ROOT;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (cur_ff == '0) begin
               mem_wr_en = 1'b1;
               finish    = 1'b1;
               state_in  = S_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = parent_idx;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_wr_en = 1'b1;
            if (gt) begin
               // Move the parent down into the hole and climb.
               mem_wr_data = rd_ent;
               cur_in      = parent_idx;
               state_in    = S_UP_RD;
            end else begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RM_ROOT: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_in    = S_RM_LAST;
         end
         S_RM_LAST: begin
            rm_ent_in = rd_ent;
            if (fill_ff == '0) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = fill_ff[bmhq_pkg::IDX_W-1:0];
               state_in    = S_DN_LOAD;
            end
         end
         S_DN_LOAD: begin
            mov_in   = rd_ent;
            cur_in   = '0;
            state_in = S_DN_RDL;
         end
         S_DN_RDL: begin
            if (has_left) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = left_w[bmhq_pkg::IDX_W-1:0];
               state_in    = S_DN_RDR;
            end else begin
               mem_wr_en = 1'b1;
               finish    = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_DN_RDR: begin
            big_in     = rd_ent;
            big_idx_in = left_w[bmhq_pkg::IDX_W-1:0];
            if (has_right) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = right_w[bmhq_pkg::IDX_W-1:0];
               state_in    = S_DN_SEL;
            end else begin
               state_in = S_DN_SWAP;
            end
         end
         S_DN_SEL: begin
            // Take the right child only when strictly larger.
            if (gt) begin
               big_in     = rd_ent;
               big_idx_in = right_w[bmhq_pkg::IDX_W-1:0];
            end
            state_in = S_DN_SWAP;
         end
         S_DN_SWAP: begin
            mem_wr_en = 1'b1;
            if (gt) begin
               mem_wr_data = big_ff;
               cur_in      = big_idx_ff;
               state_in    = S_DN_RDL;
            end else begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign removed = (fin_status == bmhq_pkg::ST_OK) && rem_ff;

   always_comb begin
      result.done          = finish;
      result.status        = fin_status;
      result.removed_valid = removed;
      result.entry_count   = bmhq_pkg::COUNT_W'(fill_ff);
      if (!removed) begin
         result.ent = '0;
      end else if (state_ff == S_RM_LAST) begin
         result.ent = rd_ent;
      end else begin
         result.ent = rm_ent_ff;
      end
   end

   assign idle = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         rem_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rem_ff   <= rem_in;
      end
      cur_ff     <= cur_in;
      big_idx_ff <= big_idx_in;
      mov_ff     <= mov_in;
      big_ff     <= big_in;
      rm_ent_ff  <= rm_ent_in;
   end

   `BMHQ_ASSERT_HOLDS(a_fill_bound, fill_ff <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY),
      "fill count above capacity")
   `BMHQ_ASSERT_IMPL(a_wr_in_heap, mem_wr_en,
      bmhq_pkg::CNT_W'(mem_wr_addr) < fill_ff, "write outside live heap")
   `BMHQ_ASSERT_IMPL(a_full_drop, finish && fin_status == bmhq_pkg::ST_FULL,
      fill_ff == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY), "full flagged below capacity")
   `BMHQ_ASSERT_IMPL(a_start_idle, start, state_ff == S_IDLE,
      "item started while busy")

endmodule

@@ bench/tb_binary_max_heap_queue_top.sv @@
`timescale 1ns / 100ps
// Testbench for the binary max-heap priority queue: heap predictor, scoreboard and drivers.

typedef struct {
   logic signed [bmhq_pkg::KEY_W-1:0] key;
   logic [bmhq_pkg::TAG_W-1:0]        tag;
   logic                              removed;
   bmhq_pkg::status_type              status;
   logic [bmhq_pkg::COUNT_W-1:0]      count;
} heap_response_type;

class heap_scoreboard;
   logic signed [bmhq_pkg::KEY_W-1:0] keys [bmhq_pkg::CAPACITY];
   logic [bmhq_pkg::TAG_W-1:0]        tags [bmhq_pkg::CAPACITY];
   int                                fill;
   int                                failures;
   heap_response_type                 pending_responses [$];

   function new();
      fill = 0;
      failures = 0;
   endfunction

   function int level();
      return fill;
   endfunction

   function int pending();
      return pending_responses.size();
   endfunction

   function void exchange(int i, int j);
      logic signed [bmhq_pkg::KEY_W-1:0] k;
      logic [bmhq_pkg::TAG_W-1:0]        t;
      k = keys[i];
      t = tags[i];
      keys[i] = keys[j];
      tags[i] = tags[j];
      keys[j] = k;
      tags[j] = t;
   endfunction

   // Apply one accepted request to the heap and queue the response it must give.
   function void note_request(logic act, logic [bmhq_pkg::KEY_W-1:0] key,
                              logic [bmhq_pkg::TAG_W-1:0] tag);
      heap_response_type rsp;
      int cur;
      int par;
      int lft;
      int big;
      rsp.key = '0;
      rsp.tag = '0;
      rsp.removed = 1'b0;
      rsp.status = bmhq_pkg::ST_OK;
      if (act == bmhq_pkg::ACT_INSERT) begin
         if (fill >= bmhq_pkg::CAPACITY) begin
            rsp.status = bmhq_pkg::ST_FULL;
         end else begin
            cur = fill;
            keys[cur] = key;
            tags[cur] = tag;
            fill++;
            // climb while strictly greater than the parent
            while (cur > 0) begin
               par = (cur - 1) / 2;
               if (!(keys[cur] > keys[par])) break;
               exchange(cur, par);
               cur = par;
            end
         end
      end else begin
         if (fill == 0) begin
            rsp.status = bmhq_pkg::ST_EMPTY;
         end else begin
            rsp.key = keys[0];
            rsp.tag = tags[0];
            rsp.removed = 1'b1;
            fill--;
            keys[0] = keys[fill];
            tags[0] = tags[fill];
            cur = 0;
            // sink toward the larger child; left wins on a tie
            while (2 * cur + 1 < fill) begin
               lft = 2 * cur + 1;
               big = lft;
               if (lft + 1 < fill && keys[lft + 1] > keys[lft]) big = lft + 1;
               if (!(keys[big] > keys[cur])) break;
               exchange(cur, big);
               cur = big;
            end
         end
      end
      rsp.count = fill[bmhq_pkg::COUNT_W-1:0];
      pending_responses.push_back(rsp);
   endfunction

   function void check_response(logic [bmhq_pkg::KEY_W-1:0] key,
                                logic [bmhq_pkg::TAG_W-1:0] tag, logic removed,
                                logic [1:0] status, logic [bmhq_pkg::COUNT_W-1:0] count);
      heap_response_type exp;
      if (pending_responses.size() == 0) begin
         $error("unexpected response item: key %0d tag %0d", $signed(key), tag);
         failures++;
         return;
      end
      exp = pending_responses.pop_front();
      if (key !== exp.key) begin
         $error("rsp_out_key: expected %0d, got %0d", exp.key, $signed(key));
         failures++;
      end
      if (tag !== exp.tag) begin
         $error("rsp_out_tag: expected %0d, got %0d", exp.tag, tag);
         failures++;
      end
      if (removed !== exp.removed) begin
         $error("rsp_removed_valid: expected %0d, got %0d", exp.removed, removed);
         failures++;
      end
      if (status !== exp.status) begin
         $error("rsp_status: expected %0d, got %0d", exp.status, status);
         failures++;
      end
      if (count !== exp.count) begin
         $error("rsp_entry_count: expected %0d, got %0d", exp.count, count);
         failures++;
      end
   endfunction
endclass

module tb_binary_max_heap_queue_top;

   localparam int ITEM_COUNT  = 1600;
   localparam int QUIET_START = 1400;
   localparam int QUIET_LIMIT = 3000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_action = bmhq_pkg::ACT_INSERT;
   logic signed [bmhq_pkg::KEY_W-1:0] req_in_key = '0;
   logic [bmhq_pkg::TAG_W-1:0]        req_in_tag = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [bmhq_pkg::KEY_W-1:0] rsp_out_key;
   logic [bmhq_pkg::TAG_W-1:0]        rsp_out_tag;
   logic                              rsp_removed_valid;
   logic [1:0]                        rsp_status;
   logic [bmhq_pkg::COUNT_W-1:0]      rsp_entry_count;

   heap_scoreboard heap_sb;
   int issued = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   binary_max_heap_queue_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_in_key        (req_in_key),
      .req_in_tag        (req_in_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_removed_valid (rsp_removed_valid),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   always #5 clock = ~clock;

   function automatic logic [bmhq_pkg::KEY_W-1:0] next_key(int mode);
      logic [bmhq_pkg::KEY_W-1:0] k;
      case (mode)
         0: k = $urandom();
         1: k = $urandom_range(0, 8) - 4;  // narrow range: many equal keys
         2: begin
            case ($urandom_range(0, 3))
               0: k = 32'h7FFF_FFFF;
               1: k = 32'h8000_0000;
               2: k = 32'h0000_0000;
               default: k = 32'hFFFF_FFFF;
            endcase
         end
         default: k = ($urandom_range(0, 200) - 100) << 16;
      endcase
      return k;
   endfunction

   function automatic logic [bmhq_pkg::TAG_W-1:0] next_tag();
      return bmhq_pkg::TAG_W'($urandom());
   endfunction

   task automatic send_request(input logic act, input logic [bmhq_pkg::KEY_W-1:0] key,
                               input logic [bmhq_pkg::TAG_W-1:0] tag);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_in_key <= key;
      req_in_tag <= tag;
      do @(posedge clock); while (req_stall);
      heap_sb.note_request(act, key, tag);
      issued++;
   endtask

   task automatic insert_entry(input logic [bmhq_pkg::KEY_W-1:0] key,
                               input logic [bmhq_pkg::TAG_W-1:0] tag);
      send_request(bmhq_pkg::ACT_INSERT, key, tag);
   endtask

   task automatic remove_top();
      send_request(bmhq_pkg::ACT_REMOVE, $urandom(), next_tag());
   endtask

   // Check responses, track progress for the watchdog, and stall the result side in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         quiet_cycles <= 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            heap_sb.check_response(rsp_out_key, rsp_out_tag, rsp_removed_valid, rsp_status,
                                   rsp_entry_count);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("[binary_max_heap_queue_top] ERROR");
      $finish;
   end

   initial begin
      int kind;
      int key_mode;
      int ins_pct;
      heap_sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty removes, key extremes, equal keys, drain past empty
      send_request(bmhq_pkg::ACT_REMOVE, 32'h0000_0000, 16'h0000);
      send_request(bmhq_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
      insert_entry(32'h7FFF_FFFF, 16'hFFFF);
      insert_entry(32'h8000_0000, 16'h0000);
      insert_entry(32'h0000_0000, 16'h0001);
      insert_entry(32'hFFFF_FFFF, 16'h0002);
      insert_entry(32'h0001_0000, 16'h0003);
      insert_entry(32'h0001_0000, 16'h0004);
      insert_entry(32'h0001_0000, 16'h0005);
      insert_entry(32'hFFFF_FFFF, 16'h0006);
      repeat (9) remove_top();

      while (issued < ITEM_COUNT) begin
         if (issued >= QUIET_START) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 10;
               default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 40;
            endcase
         end
         kind = $urandom_range(0, 9);
         key_mode = $urandom_range(0, 3);
         if (kind < 2) begin
            // fill to capacity, then push a few into the full heap
            while (heap_sb.level() < bmhq_pkg::CAPACITY)
               insert_entry(next_key(key_mode), next_tag());
            repeat ($urandom_range(1, 4)) insert_entry(next_key(key_mode), next_tag());
         end else if (kind < 4) begin
            while (heap_sb.level() > 0) remove_top();
            repeat ($urandom_range(1, 3)) remove_top();
         end else begin
            ins_pct = $urandom_range(30, 70);
            repeat ($urandom_range(20, 60)) begin
               if ($urandom_range(0, 99) < ins_pct)
                  insert_entry(next_key(key_mode), next_tag());
               else
                  remove_top();
            end
         end
      end
      req_valid <= 1'b0;

      while (heap_sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (heap_sb.failures == 0)
         $display("[binary_max_heap_queue_top] OK");
      else
         $display("[binary_max_heap_queue_top] ERROR");
      $finish;
   end

endmodule
